FILE: hdl/motor_speed_pi_loop_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor speed PI loop
// Clocked on clk, disabled while rst_n is low; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PI_LOOP_UNIT_ASSERT_SVH
`define MOTOR_SPEED_PI_LOOP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MSPL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mspl assertion failed");
`define MSPL_NEVER(label, cond) \
  `MSPL_ASSERT(label, !(cond))
`else
`define MSPL_ASSERT(label, prop)
`define MSPL_NEVER(label, cond)
`endif

`endif

FILE: hdl/mspl_pkg.sv
// ----------------------------------------------------------------------------
// mspl_pkg
// Types and constants shared by the motor speed PI loop modules.
// ----------------------------------------------------------------------------
package mspl_pkg;

  localparam int SPEED_W  = 16;
  localparam int PERIOD_W = 32;
  localparam int GAIN_W   = 16;
  localparam int ERR_W    = SPEED_W + 1;
  localparam int SUM_W    = 48;
  localparam int SUM_LO_W = SUM_W / 2;
  localparam int SUM_HI_W = SUM_W - SUM_LO_W;
  localparam int PROP_SH  = 17;
  localparam int FRAC_SH  = 33;
  localparam int TOT_W    = 66;
  localparam int Q_W      = TOT_W - FRAC_SH;
  localparam int DUTY_W   = Q_W + 1;
  localparam int DIV_STEPS = PERIOD_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 16'd5243;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = 16'd4295;
  localparam logic [SPEED_W-1:0]  DEAD_BAND_RST   = 16'd20;
  localparam logic [SPEED_W-1:0]  PWM_PERIOD_RST  = 16'd1200;
  localparam logic [PERIOD_W-1:0] SPEED_SCALE_RST = 32'd90000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DEAD_BAND   = 3'd2,
    REG_PWM_PERIOD  = 3'd3,
    REG_SPEED_SCALE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [SPEED_W-1:0]  dead_band;
    logic [SPEED_W-1:0]  pwm_period;
    logic [PERIOD_W-1:0] speed_scale;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_LO,
    S_MUL_HI,
    S_ACC,
    S_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic acc;
    logic upd;
  } cmd_t;

endpackage

FILE: hdl/mspl_ctrl.sv
// ----------------------------------------------------------------------------
// mspl_ctrl
// Sequencer: accept, divide steps, multiply, accumulate, update and output.
// ----------------------------------------------------------------------------
`include "motor_speed_pi_loop_unit_assert.svh"

module mspl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               out_stall,
  output logic               out_valid,
  output mspl_pkg::cmd_t     cmd
);

  mspl_pkg::state_t               state_r, state_nxt;
  logic [mspl_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      mspl_pkg::S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) state_nxt = mspl_pkg::S_DIV;
      end
      mspl_pkg::S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == mspl_pkg::DIV_LAST) state_nxt = mspl_pkg::S_MUL_LO;
      end
      mspl_pkg::S_MUL_LO: state_nxt = mspl_pkg::S_MUL_HI;
      mspl_pkg::S_MUL_HI: state_nxt = mspl_pkg::S_ACC;
      mspl_pkg::S_ACC:    state_nxt = mspl_pkg::S_UPD;
      mspl_pkg::S_UPD: begin
        // wait while the previous result is still held up
        if (!(out_valid_r && out_stall)) state_nxt = mspl_pkg::S_IDLE;
      end
      default: state_nxt = mspl_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      mspl_pkg::S_IDLE:   cmd.load     = in_valid;
      mspl_pkg::S_DIV:    cmd.div_step = 1'b1;
      mspl_pkg::S_MUL_LO: cmd.mul_lo   = 1'b1;
      mspl_pkg::S_MUL_HI: cmd.mul_hi   = 1'b1;
      mspl_pkg::S_ACC:    cmd.acc      = 1'b1;
      mspl_pkg::S_UPD:    cmd.upd      = !(out_valid_r && out_stall);
      default:            cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.upd) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mspl_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != mspl_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  `MSPL_ASSERT(a_cmd_onehot, $onehot0(cmd))
  `MSPL_ASSERT(a_load_starts_div, cmd.load |=> (state_r == mspl_pkg::S_DIV) && (cnt_r == '0))
  `MSPL_ASSERT(a_div_full_len, (state_r == mspl_pkg::S_MUL_LO) |-> ($past(cnt_r) == mspl_pkg::DIV_LAST))
  `MSPL_NEVER(a_no_overwrite, cmd.upd && out_valid_r && out_stall)

endmodule

FILE: hdl/mspl_dpath.sv
// ----------------------------------------------------------------------------
// mspl_dpath
// Restoring divider, split integral multiply, PI sum and duty update.
// ----------------------------------------------------------------------------
`include "motor_speed_pi_loop_unit_assert.svh"

module mspl_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mspl_pkg::cmd_t                    cmd,
  input  mspl_pkg::cfg_t                    cfg,
  input  logic [mspl_pkg::SPEED_W-1:0]      in_target_speed,
  input  logic [mspl_pkg::PERIOD_W-1:0]     in_period_count,
  output logic [mspl_pkg::SPEED_W-1:0]      out_pwm_duty,
  output logic [mspl_pkg::SPEED_W-1:0]      out_shown_speed,
  output logic [mspl_pkg::SPEED_W-1:0]      out_measured_speed
);

  localparam int SW  = mspl_pkg::SPEED_W;
  localparam int PW  = mspl_pkg::PERIOD_W;
  localparam int GW  = mspl_pkg::GAIN_W;
  localparam int EW  = mspl_pkg::ERR_W;
  localparam int SMW = mspl_pkg::SUM_W;
  localparam int LW  = mspl_pkg::SUM_LO_W;
  localparam int HW  = mspl_pkg::SUM_HI_W;
  localparam int TW  = mspl_pkg::TOT_W;
  localparam int QW  = mspl_pkg::Q_W;
  localparam int DW  = mspl_pkg::DUTY_W;
  localparam int FS  = mspl_pkg::FRAC_SH;

  // controller state
  logic signed [SMW-1:0] error_sum_r, error_sum_nxt;
  logic [SW-1:0]         duty_level_r, duty_level_nxt;
  logic [SW-1:0]         held_r, held_nxt;
  logic [SW-1:0]         shown_r, shown_nxt;

  // per-request working registers
  logic [SW-1:0]         target_r;
  logic [PW-1:0]         period_r;
  logic signed [EW-1:0]  err_r;
  logic [PW-1:0]         quo_r, rem_r;
  logic [GW+LW-1:0]      plo_r;
  logic signed [GW+HW:0] phi_r;
  logic signed [GW+EW:0] pe_r;
  logic signed [QW-1:0]  q_r;
  logic [SW-1:0]         duty_out_r, shown_out_r, meas_out_r;

  logic signed [EW-1:0]  err_w;
  logic [PW:0]           trial_w;
  logic signed [TW-1:0]  tot_w;
  logic signed [QW-1:0]  q_w;
  logic [SW-1:0]         meas_w;
  logic [EW-1:0]         mag_w;
  logic                  outside_w;
  logic signed [DW-1:0]  duty_sum_w;

  assign err_w = $signed({1'b0, in_target_speed}) - $signed({1'b0, held_r});

  // one quotient bit per step
  assign trial_w = {rem_r, quo_r[PW-1]} - {1'b0, period_r};

  assign tot_w = ($signed({{(TW-GW-HW-1){phi_r[GW+HW]}}, phi_r}) <<< LW)
               + $signed({{(TW-GW-LW){1'b0}}, plo_r})
               + ($signed({{(TW-GW-EW-1){pe_r[GW+EW]}}, pe_r}) <<< mspl_pkg::PROP_SH);

  // floor shift, then bump negatives with a fraction to truncate toward zero
  assign q_w = tot_w[TW-1:FS] + QW'(tot_w[TW-1] && (|tot_w[FS-1:0]));

  always_comb begin
    if (period_r == '0) meas_w = '0;
    else if (|quo_r[PW-1:SW]) meas_w = '1;
    else meas_w = quo_r[SW-1:0];
  end

  assign mag_w     = err_r[EW-1] ? EW'(-err_r) : EW'(err_r);
  assign outside_w = mag_w > {1'b0, cfg.dead_band};
  assign duty_sum_w = $signed({{(DW-SW){1'b0}}, duty_level_r}) + $signed({q_r[QW-1], q_r});

  always_comb begin
    error_sum_nxt  = error_sum_r;
    duty_level_nxt = duty_level_r;
    held_nxt       = held_r;
    shown_nxt      = shown_r;
    if (cmd.load) error_sum_nxt = error_sum_r + SMW'(err_w);
    if (cmd.upd) begin
      held_nxt = meas_w;
      if (err_r != '0) shown_nxt = target_r;
      if (outside_w) begin
        shown_nxt = meas_w;
        if (duty_sum_w[DW-1]) duty_level_nxt = '0;
        else if (duty_sum_w > $signed({{(DW-SW){1'b0}}, cfg.pwm_period}))
          duty_level_nxt = cfg.pwm_period;
        else duty_level_nxt = duty_sum_w[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r  <= '0;
      duty_level_r <= '0;
      held_r       <= '0;
      shown_r      <= '0;
    end else begin
      error_sum_r  <= error_sum_nxt;
      duty_level_r <= duty_level_nxt;
      held_r       <= held_nxt;
      shown_r      <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r <= in_target_speed;
      period_r <= in_period_count;
      err_r    <= err_w;
      quo_r    <= cfg.speed_scale;
      rem_r    <= '0;
    end
    if (cmd.div_step) begin
      if (!trial_w[PW]) begin
        rem_r <= trial_w[PW-1:0];
        quo_r <= {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[PW-2:0], quo_r[PW-1]};
        quo_r <= {quo_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.mul_lo) plo_r <= cfg.integ_gain * error_sum_r[LW-1:0];
    if (cmd.mul_hi) begin
      phi_r <= $signed({1'b0, cfg.integ_gain}) * $signed(error_sum_r[SMW-1:LW]);
      pe_r  <= $signed({1'b0, cfg.prop_gain}) * err_r;
    end
    if (cmd.acc) q_r <= q_w;
    if (cmd.upd) begin
      duty_out_r  <= duty_level_nxt;
      shown_out_r <= shown_nxt;
      meas_out_r  <= meas_w;
    end
  end

  assign out_pwm_duty       = duty_out_r;
  assign out_shown_speed    = shown_out_r;
  assign out_measured_speed = meas_out_r;

  // inside the deadband the old duty is kept, even above a lowered ceiling
  `MSPL_ASSERT(a_duty_in_range, (cmd.upd && outside_w) |=> duty_level_r <= $past(cfg.pwm_period))
  `MSPL_ASSERT(a_held_tracks, cmd.upd |=> (held_r == $past(meas_w)))
  `MSPL_ASSERT(a_zero_period, (cmd.upd && (period_r == '0)) |=> (out_measured_speed == '0))

endmodule

FILE: hdl/motor_speed_pi_loop_unit.sv
// ----------------------------------------------------------------------------
// motor_speed_pi_loop_unit
// Incremental PI speed controller with deadband, one request per control tick.
// ----------------------------------------------------------------------------
// A request is taken in S_IDLE; the 32-step restoring divider of the speed
// measurement runs, then the MUL_LO and MUL_HI multiply states, ACC and UPD.
// in_stall holds off new requests until the unit is back in S_IDLE.
// The next request is taken while a finished result waits on out_stall.
// Reset (synchronous, rst_n low): integrator, duty, held and shown speed
// cleared, registers back to defaults, no result pending.
module motor_speed_pi_loop_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mspl_pkg::SPEED_W-1:0]          in_target_speed,
  input  logic [mspl_pkg::PERIOD_W-1:0]         in_period_count,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mspl_pkg::SPEED_W-1:0]          out_pwm_duty,
  output logic [mspl_pkg::SPEED_W-1:0]          out_shown_speed,
  output logic [mspl_pkg::SPEED_W-1:0]          out_measured_speed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mspl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mspl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mspl_pkg::cfg_t cfg_r, cfg_nxt;
  mspl_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        mspl_pkg::REG_PROP_GAIN:   cfg_nxt.prop_gain   = cfg_data[mspl_pkg::GAIN_W-1:0];
        mspl_pkg::REG_INTEG_GAIN:  cfg_nxt.integ_gain  = cfg_data[mspl_pkg::GAIN_W-1:0];
        mspl_pkg::REG_DEAD_BAND:   cfg_nxt.dead_band   = cfg_data[mspl_pkg::SPEED_W-1:0];
        mspl_pkg::REG_PWM_PERIOD:  cfg_nxt.pwm_period  = cfg_data[mspl_pkg::SPEED_W-1:0];
        mspl_pkg::REG_SPEED_SCALE: cfg_nxt.speed_scale = cfg_data[mspl_pkg::PERIOD_W-1:0];
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= mspl_pkg::PROP_GAIN_RST;
      cfg_r.integ_gain  <= mspl_pkg::INTEG_GAIN_RST;
      cfg_r.dead_band   <= mspl_pkg::DEAD_BAND_RST;
      cfg_r.pwm_period  <= mspl_pkg::PWM_PERIOD_RST;
      cfg_r.speed_scale <= mspl_pkg::SPEED_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mspl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mspl_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_target_speed    (in_target_speed),
    .in_period_count    (in_period_count),
    .out_pwm_duty       (out_pwm_duty),
    .out_shown_speed    (out_shown_speed),
    .out_measured_speed (out_measured_speed)
  );

endmodule
